// File: hdl/jia_pkg.sv
// jia_pkg: opcodes, branch condition codes and pipeline payload types
// for the integer alu; no dependencies
package jia_pkg;

	localparam logic [4:0] OP_ADD    = 5'd0;
	localparam logic [4:0] OP_SUB    = 5'd1;
	localparam logic [4:0] OP_MUL    = 5'd2;
	localparam logic [4:0] OP_DIV    = 5'd3;
	localparam logic [4:0] OP_REM    = 5'd4;
	localparam logic [4:0] OP_NEG    = 5'd5;
	localparam logic [4:0] OP_SHL    = 5'd6;
	localparam logic [4:0] OP_SHR    = 5'd7;
	localparam logic [4:0] OP_USHR   = 5'd8;
	localparam logic [4:0] OP_AND    = 5'd9;
	localparam logic [4:0] OP_OR     = 5'd10;
	localparam logic [4:0] OP_XOR    = 5'd11;
	localparam logic [4:0] OP_CMP    = 5'd12;
	localparam logic [4:0] OP_I2L    = 5'd13;
	localparam logic [4:0] OP_L2I    = 5'd14;
	localparam logic [4:0] OP_I2B    = 5'd15;
	localparam logic [4:0] OP_I2S    = 5'd16;
	localparam logic [4:0] OP_I2C    = 5'd17;
	localparam logic [4:0] OP_IFZERO = 5'd18;
	localparam logic [4:0] OP_IFCMP  = 5'd19;

	localparam logic [2:0] COND_EQ = 3'd0;
	localparam logic [2:0] COND_NE = 3'd1;
	localparam logic [2:0] COND_LT = 3'd2;
	localparam logic [2:0] COND_LE = 3'd3;
	localparam logic [2:0] COND_GT = 3'd4;
	localparam logic [2:0] COND_GE = 3'd5;

	localparam int DIV_STEPS = 64;

	typedef struct packed {
		logic [4:0]  op;
		logic        narrow;
		logic        na;
		logic        nb;
		logic        dz;
		logic        taken;
		logic [63:0] res;
	} jia_meta_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] dvs;
	} jia_div_t;

endpackage

// File: hdl/jia_front.sv
// jia_front: operand capture, sign extension, the simple operations and
// multiply/divide set-up (two register stages); depends on jia_pkg
module jia_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic              in_valid,
	input  logic [4:0]        op,
	input  logic              is_long,
	input  logic [2:0]        cond,
	input  logic [63:0]       first_operand,
	input  logic [63:0]       second_operand,
	output logic              valid_s2,
	output jia_pkg::jia_meta_t meta_s2,
	output jia_pkg::jia_div_t  div_s2,
	output logic [63:0]       p0_s2,
	output logic [31:0]       p1_s2,
	output logic [31:0]       p2_s2
);
	import jia_pkg::*;

	logic        valid_s1;
	logic [4:0]  op_s1;
	logic        wide_s1;
	logic [2:0]  cond_s1;
	logic [63:0] a_s1;
	logic [63:0] b_s1;

	function automatic logic test_cond(input logic [2:0] c, input logic [63:0] x,
		input logic [63:0] y);
		logic eq;
		logic lt;
		logic gt;
		begin
			eq = (x == y);
			lt = $signed(x) < $signed(y);
			gt = $signed(y) < $signed(x);
			case (c)
				COND_EQ: test_cond = eq;
				COND_NE: test_cond = !eq;
				COND_LT: test_cond = lt;
				COND_LE: test_cond = !gt;
				COND_GT: test_cond = gt;
				COND_GE: test_cond = !lt;
				default: test_cond = 1'b0;
			endcase
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1   <= op;
			wide_s1 <= is_long;
			cond_s1 <= cond;
			a_s1    <= is_long ? first_operand : {{32{first_operand[31]}}, first_operand[31:0]};
			b_s1    <= is_long ? second_operand
				: {{32{second_operand[31]}}, second_operand[31:0]};
		end
	end

	logic [5:0]  shamt;
	logic [63:0] res;
	logic        taken;
	logic        na;
	logic        nb;
	logic [63:0] ma;
	logic [63:0] mb;

	always_comb begin
		shamt = wide_s1 ? b_s1[5:0] : {1'b0, b_s1[4:0]};
		na    = a_s1[63];
		nb    = b_s1[63];
		ma    = na ? 64'd0 - a_s1 : a_s1;
		mb    = nb ? 64'd0 - b_s1 : b_s1;
		taken = 1'b0;
		case (op_s1)
			OP_ADD:  res = a_s1 + b_s1;
			OP_SUB:  res = a_s1 - b_s1;
			OP_NEG:  res = 64'd0 - a_s1;
			OP_SHL:  res = a_s1 << shamt;
			OP_SHR:  res = 64'($signed(a_s1) >>> shamt);
			OP_USHR: res = (wide_s1 ? a_s1 : {32'd0, a_s1[31:0]}) >> shamt;
			OP_AND:  res = a_s1 & b_s1;
			OP_OR:   res = a_s1 | b_s1;
			OP_XOR:  res = a_s1 ^ b_s1;
			OP_CMP:  res = (a_s1 == b_s1) ? 64'd0
				: (($signed(b_s1) < $signed(a_s1)) ? 64'd1 : {64{1'b1}});
			OP_I2L, OP_L2I: res = {{32{a_s1[31]}}, a_s1[31:0]};
			OP_I2B:  res = {{56{a_s1[7]}}, a_s1[7:0]};
			OP_I2S:  res = {{48{a_s1[15]}}, a_s1[15:0]};
			OP_I2C:  res = {48'd0, a_s1[15:0]};
			OP_IFZERO: begin
				res   = 64'd0;
				taken = test_cond(cond_s1, a_s1, 64'd0);
			end
			OP_IFCMP: begin
				res   = 64'd0;
				taken = test_cond(cond_s1, a_s1, b_s1);
			end
			default: res = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			meta_s2.op     <= op_s1;
			meta_s2.narrow <= !wide_s1 && (op_s1 inside {[OP_ADD:OP_XOR]});
			meta_s2.na     <= na;
			meta_s2.nb     <= nb;
			meta_s2.dz     <= (op_s1 == OP_DIV || op_s1 == OP_REM) && (b_s1 == 64'd0);
			meta_s2.taken  <= taken;
			meta_s2.res    <= res;
			div_s2.rem     <= 64'd0;
			div_s2.quo     <= ma;
			div_s2.dvs     <= mb;
			// low 64 bits of the product need only three partial products
			p0_s2 <= 64'(a_s1[31:0]) * 64'(b_s1[31:0]);
			p1_s2 <= 32'(a_s1[31:0] * b_s1[63:32]);
			p2_s2 <= 32'(a_s1[63:32] * b_s1[31:0]);
		end
	end

endmodule

// File: hdl/jia_div_step.sv
// jia_div_step: one registered restoring-division step, carrying the
// item's sideband along; depends on jia_pkg
module jia_div_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               valid_in,
	input  jia_pkg::jia_meta_t meta_in,
	input  jia_pkg::jia_div_t  div_in,
	output logic               valid_out,
	output jia_pkg::jia_meta_t meta_out,
	output jia_pkg::jia_div_t  div_out
);
	import jia_pkg::*;

	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;

	always_comb begin
		trial = {div_in.rem, div_in.quo[63]};
		diff  = trial - {1'b0, div_in.dvs};
		ge    = !diff[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (ce) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			meta_out    <= meta_in;
			div_out.rem <= ge ? diff[63:0] : trial[63:0];
			div_out.quo <= {div_in.quo[62:0], ge};
			div_out.dvs <= div_in.dvs;
		end
	end

endmodule

// File: hdl/jvm_integer_alu.sv
// jvm_integer_alu: top level of the pipelined java integer alu
// depends on jia_pkg, jia_front and jia_div_step
//
// usage
//  - input channel s_axis: one word per operation; tdata carries the two
//    operands, tuser the opcode, the long flag and the branch condition
//  - output channel m_axis: one word per operation, in order; tdata holds
//    the result, tuser the branch-taken and divide-by-zero flags
//  - every operation runs the same 68-register path: two front stages,
//    one stage that sums the multiplier partial products, 64 one-bit
//    divider stages and the output register, whatever the opcode
//  - throughput is one word per cycle unless the receiver stalls; the 64-stage divider chain sets
//    the latency, the whole path advances as one
//  - when the receiver drops m_axis_tready while a word is shown, the
//    whole pipeline holds, bubbles included, and s_axis_tready falls in
//    the same cycle; nothing is dropped or repeated
//  - reset empties all valid bits; payload registers are not cleared
module jvm_integer_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // first_operand[63:0], second_operand[127:64]
	input  logic [8:0]    s_axis_tuser,  // op[4:0], is_long[5], cond[8:6]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,  // result_value[63:0]
	output logic [1:0]    m_axis_tuser   // branch_taken[0], divide_by_zero[1]
);
	import jia_pkg::*;

	// whole pipeline moves when the output register is free or being taken
	logic ce;
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	logic        valid_s2;
	jia_meta_t   meta_s2;
	jia_div_t    div_s2;
	logic [63:0] p0_s2;
	logic [31:0] p1_s2;
	logic [31:0] p2_s2;

	jia_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.ce            (ce),
		.in_valid      (s_axis_tvalid),
		.op            (s_axis_tuser[4:0]),
		.is_long       (s_axis_tuser[5]),
		.cond          (s_axis_tuser[8:6]),
		.first_operand (s_axis_tdata[63:0]),
		.second_operand(s_axis_tdata[127:64]),
		.valid_s2      (valid_s2),
		.meta_s2       (meta_s2),
		.div_s2        (div_s2),
		.p0_s2         (p0_s2),
		.p1_s2         (p1_s2),
		.p2_s2         (p2_s2)
	);

	// stage 3: fold the multiplier partial products into the result
	logic      valid_s3;
	jia_meta_t meta_s3;
	jia_div_t  div_s3;
	jia_meta_t meta_mul;

	always_comb begin
		meta_mul = meta_s2;
		if (meta_s2.op == OP_MUL) begin
			meta_mul.res = p0_s2 + {p1_s2 + p2_s2, 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ce) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			meta_s3 <= meta_mul;
			div_s3  <= div_s2;
		end
	end

	// divider chain, one quotient bit per stage
	logic      dvalid [0:DIV_STEPS];
	jia_meta_t dmeta  [0:DIV_STEPS];
	jia_div_t  ddiv   [0:DIV_STEPS];

	assign dvalid[0] = valid_s3;
	assign dmeta[0]  = meta_s3;
	assign ddiv[0]   = div_s3;

	genvar gi;
	generate
		for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
			jia_div_step u_step (
				.clk      (clk),
				.arst_n   (arst_n),
				.ce       (ce),
				.valid_in (dvalid[gi]),
				.meta_in  (dmeta[gi]),
				.div_in   (ddiv[gi]),
				.valid_out(dvalid[gi+1]),
				.meta_out (dmeta[gi+1]),
				.div_out  (ddiv[gi+1])
			);
		end
	endgenerate

	// final selection: signed quotient or remainder, then int narrowing
	jia_meta_t   fm;
	jia_div_t    fd;
	logic [63:0] fres;

	always_comb begin
		fm   = dmeta[DIV_STEPS];
		fd   = ddiv[DIV_STEPS];
		fres = fm.res;
		if (fm.op == OP_DIV) begin
			fres = fm.dz ? 64'd0 : ((fm.na ^ fm.nb) ? 64'd0 - fd.quo : fd.quo);
		end else if (fm.op == OP_REM) begin
			fres = fm.dz ? 64'd0 : (fm.na ? 64'd0 - fd.rem : fd.rem);
		end
		if (fm.narrow) begin
			fres = {{32{fres[31]}}, fres[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			m_axis_tvalid <= dvalid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata <= fres;
			m_axis_tuser <= {fm.dz, fm.taken};
		end
	end

`ifndef SYNTHESIS
	// a zero divisor always yields a zero result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
		else $error("divide by zero with nonzero result");

	// branch and divide flags never come together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("branch and divide flags both set");

	// a taken branch carries a zero result
	a_branch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
		else $error("taken branch with nonzero result");

	// a stalled output word holds while the pipeline is frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed during stall");
`endif

endmodule
